### hw/rtl/aes_block_cipher_defines.svh
// Assertion macros shared by the AES block cipher RTL
`ifndef AES_BLOCK_CIPHER_DEFINES_SVH
`define AES_BLOCK_CIPHER_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/aes_pkg.sv
package aes_pkg;

	localparam int KeyWords = 4;
	localparam int Rounds   = 10;
	localparam int RkDepth  = 4 * (Rounds + 1);
	localparam int RkAw     = $clog2(RkDepth);
	localparam int CellCnt  = 2 * Rounds;
	localparam int RndW     = $clog2(Rounds + 1);

	localparam logic [1:0] CfgKey0 = 2'd0;
	localparam logic [1:0] CfgKey1 = 2'd1;
	localparam logic [1:0] CfgKey2 = 2'd2;

	localparam logic OpEnc = 1'b0;
	localparam logic OpDec = 1'b1;

	typedef logic [127:0] blk_t;

	typedef struct packed {
		logic       vld;
		logic       dec;
	} ctl_t;

	typedef enum logic [1:0] {
		KS_IDLE,
		KS_RUN
	} ks_state_t;

	function automatic logic [7:0] xtime(input logic [7:0] x);
		xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] t;
		p = 8'h00;
		t = a;
		for (int i = 0; i < 4; i++) begin
			if (b[i]) p = p ^ t;
			t = xtime(t);
		end
		gmul = p;
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		sbox = t[x];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		inv_sbox = t[x];
	endfunction

	// Byte n of a block sits at bits [127-8n -: 8]
	function automatic logic [7:0] bget(input blk_t s, input int n);
		bget = s[127 - 8 * n -: 8];
	endfunction

endpackage

### hw/rtl/aes_ks.sv
module aes_ks import aes_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [3*64-1:0]   key,
	output logic              busy,
	output logic              wr_en,
	output logic [RkAw-1:0]   wr_addr,
	output logic [31:0]       wr_data
);

	ks_state_t state_q, state_d;
	logic [RkAw-1:0] idx_q;
	logic [31:0] win_q [KeyWords];
	logic [7:0] rc_q;
	logic [2:0] mod_q;
	logic [31:0] nxt;
	logic [31:0] rot;
	logic last;

	always_comb begin
		rot = {win_q[KeyWords-1][23:0], win_q[KeyWords-1][31:24]};
		if (idx_q < RkAw'(KeyWords)) begin
			nxt = key[3*64-1 - 32 * int'(idx_q) -: 32];
		end else if (mod_q == 3'd0) begin
			nxt = {sbox(rot[31:24]) ^ rc_q, sbox(rot[23:16]), sbox(rot[15:8]),
				sbox(rot[7:0])} ^ win_q[0];
		end else begin
			nxt = win_q[KeyWords-1] ^ win_q[0];
		end
	end

	assign last = (idx_q == RkAw'(RkDepth - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			KS_IDLE: if (start) state_d = KS_RUN;
			KS_RUN:  if (last && !start) state_d = KS_IDLE;
			default: state_d = KS_IDLE;
		endcase
	end

	always_comb begin
		busy    = (state_q == KS_RUN) || start;
		wr_en   = (state_q == KS_RUN) && !start;
		wr_addr = idx_q;
		wr_data = nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KS_IDLE;
			idx_q   <= '0;
			rc_q    <= 8'h01;
			mod_q   <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				idx_q <= '0;
				rc_q  <= 8'h01;
				mod_q <= '0;
			end else if (state_q == KS_RUN) begin
				idx_q <= idx_q + 1'b1;
				mod_q <= (mod_q == 3'(KeyWords - 1)) ? 3'd0 : mod_q + 3'd1;
				if (mod_q == 3'd0 && idx_q >= RkAw'(KeyWords)) rc_q <= xtime(rc_q);
			end
		end
	end

	// Sliding window of the last KeyWords words
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < KeyWords - 1; i++) win_q[i] <= win_q[i+1];
			win_q[KeyWords-1] <= nxt;
		end
	end

endmodule

### hw/rtl/aes_cell.sv
`include "aes_block_cipher_defines.svh"
module aes_cell import aes_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       half,      // 0: substitution half, 1: key and mix half
	input  logic       mix,       // mix columns used in this cell
	input  ctl_t       ctl_in,
	input  blk_t       blk_in,
	input  blk_t       rk_enc,
	input  blk_t       rk_dec,
	output ctl_t       ctl_q,
	output blk_t       blk_q
);

	blk_t sr, sb, ak, mc, res;
	logic [7:0] c [4];

	always_comb begin
		for (int n = 0; n < 16; n++) begin
			// forward shift takes from column c+r, inverse writes to it
			sr[127 - 8*n -: 8] = ctl_in.dec ?
				bget(blk_in, 4 * (((n/4) - (n%4)) & 3) + n%4) :
				bget(blk_in, 4 * (((n/4) + (n%4)) & 3) + n%4);
			sb[127 - 8*n -: 8] = ctl_in.dec ? inv_sbox(sr[127 - 8*n -: 8]) :
				sbox(sr[127 - 8*n -: 8]);
		end
		ak = blk_in ^ (ctl_in.dec ? rk_dec : rk_enc);
		for (int col = 0; col < 4; col++) begin
			for (int k = 0; k < 4; k++) c[k] = bget(ctl_in.dec ? ak : blk_in, 4*col + k);
			for (int r = 0; r < 4; r++) begin
				if (ctl_in.dec)
					mc[127 - 8*(4*col+r) -: 8] = gmul(c[r], 8'h0e) ^
						gmul(c[(r+1)&3], 8'h0b) ^ gmul(c[(r+2)&3], 8'h0d) ^
						gmul(c[(r+3)&3], 8'h09);
				else
					mc[127 - 8*(4*col+r) -: 8] = xtime(c[r]) ^ xtime(c[(r+1)&3]) ^
						c[(r+1)&3] ^ c[(r+2)&3] ^ c[(r+3)&3];
			end
		end
		if (!half)
			res = sb;
		else if (!mix)
			res = ak;
		else if (ctl_in.dec)
			res = mc;
		else
			res = mc ^ rk_enc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_q <= '0;
		else if (en) ctl_q <= ctl_in;
	end

	always_ff @(posedge clk) begin
		if (en) blk_q <= res;
	end

	`AES_ASSERT_NEXT(a_cell_hold, clk, arst_n, !en, ctl_q == $past(ctl_q), "cell moved while stalled")

endmodule

### hw/rtl/aes_block_cipher.sv
// Channel   Dir  Beat contents
// s_axis    in   tuser: opcode; tdata[63:0] block_upper, [127:64] block_lower
// m_axis    out  tdata[63:0] result_upper, [127:64] result_lower
// cfg       in   cfg_index selects key register, cfg_data holds its value
// Pipeline: an initial key add and 20 round cells; one block per cycle while the chain advances.
// After a key write s_axis_tready is low while the key schedule runs.
// Reset clears control; the round-key store is filled only by key expansion.
// The whole chain advances only when the output register is free or being taken.
`include "aes_block_cipher_defines.svh"
module aes_block_cipher import aes_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // block_upper, block_lower
	input  logic         s_axis_tuser,   // opcode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,   // result_upper, result_lower
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	logic [63:0] key_q [3];
	logic ks_start, ks_busy, ks_we;
	logic [RkAw-1:0] ks_addr;
	logic [31:0] ks_data;
	logic [31:0] rk_q [RkDepth];   // words in flops: each read at a fixed slot
	logic adv;
	ctl_t ctl0_s1;
	blk_t blk0_s1;
	ctl_t ctl_c [CellCnt];
	blk_t blk_c [CellCnt];

	function automatic blk_t rkey(input int r);
		rkey = {rk_q[4*r], rk_q[4*r+1], rk_q[4*r+2], rk_q[4*r+3]};
	endfunction

	assign cfg_ready = 1'b1;
	assign ks_start  = cfg_valid && (cfg_index == CfgKey0 || cfg_index == CfgKey1 ||
		cfg_index == CfgKey2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) key_q[i] <= '0;
		end else if (ks_start) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	aes_ks u_ks (
		.clk(clk), .arst_n(arst_n), .start(ks_start),
		.key({key_q[0], key_q[1], key_q[2]}),
		.busy(ks_busy), .wr_en(ks_we), .wr_addr(ks_addr), .wr_data(ks_data)
	);

	always_ff @(posedge clk) begin
		if (ks_we) rk_q[ks_addr] <= ks_data;
	end

	// Advance the chain whenever the tail register is empty or being drained
	assign adv = !ctl_c[CellCnt-1].vld || m_axis_tready;
	assign s_axis_tready = adv && !ks_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl0_s1 <= '0;
		else if (adv) ctl0_s1 <= '{vld: s_axis_tvalid && s_axis_tready,
			dec: s_axis_tuser};
	end

	// Initial key add: round 0 for encrypt, last round for decrypt
	always_ff @(posedge clk) begin
		if (adv) blk0_s1 <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^
			((s_axis_tuser == OpDec) ? rkey(Rounds) : rkey(0));
	end

	for (genvar g = 0; g < CellCnt; g++) begin : g_cell
		localparam int Rnd = g / 2 + 1;
		aes_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.half(g % 2 == 1), .mix(Rnd != Rounds),
			.ctl_in(g == 0 ? ctl0_s1 : ctl_c[g == 0 ? 0 : g-1]),
			.blk_in(g == 0 ? blk0_s1 : blk_c[g == 0 ? 0 : g-1]),
			.rk_enc(rkey(Rnd)), .rk_dec(rkey(Rounds - Rnd)),
			.ctl_q(ctl_c[g]), .blk_q(blk_c[g])
		);
	end

	assign m_axis_tvalid = ctl_c[CellCnt-1].vld;
	assign m_axis_tdata  = {blk_c[CellCnt-1][63:0], blk_c[CellCnt-1][127:64]};

	`AES_ASSERT_IMP(a_no_data_in_ks, clk, arst_n, ks_busy, !s_axis_tready, "beat taken during key expansion")
	`AES_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
	`AES_ASSERT_IMP(a_we_idle, clk, arst_n, ks_we, ks_busy, "schedule write while idle")

endmodule
